/* rtl/core/gmdfs_pkg.sv */
// Shared types and constants for the grid maze depth-first path search.
// Used by gmdfs_stack and grid_maze_dfs_path_search; depends on nothing.
package gmdfs_pkg;

   localparam int ROWS_DEF        = 16;
   localparam int COLS_DEF        = 16;
   localparam int STACK_DEPTH_DEF = 256;

   localparam int COORD_W   = 4;
   localparam int CFG_W     = 5;
   localparam int LEN_W     = 9;
   localparam int CMD_W     = 2;
   localparam int MARK_W    = 2;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 16;

   localparam logic [LEN_W-1:0] LEN_MAX    = 9'd511;
   localparam logic [CFG_W-1:0] SIZE_RESET = 5'd10;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [MARK_W-1:0] MARK_OPEN = 2'd0;
   localparam logic [MARK_W-1:0] MARK_WALL = 2'd1;
   localparam logic [MARK_W-1:0] MARK_PATH = 2'd2;
   localparam logic [MARK_W-1:0] MARK_DEAD = 2'd3;

   localparam logic [1:0] DIR_COL_INC = 2'd0;
   localparam logic [1:0] DIR_ROW_INC = 2'd1;
   localparam logic [1:0] DIR_COL_DEC = 2'd2;
   localparam logic [1:0] DIR_ROW_DEC = 2'd3;

   localparam logic [0:0] CSR_ROWS = 1'b0;
   localparam logic [0:0] CSR_COLS = 1'b1;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stk_ctl_type;

endpackage

/* rtl/core/grid_maze_dfs_path_search.sv */
// Grid maze solver: a ROWS x COLS grid of 2-bit marks (open, wall, path, dead end) searched
// depth first with an explicit stack. The grid memory and the stack memory both have a
// registered read, so a read word waits in ST_RD_WAIT, each cell tried waits in ST_CHECK_WAIT
// and each stack pop waits in ST_POP_WAIT. After reset a clearing pass opens every cell
// before the first request word is taken. Depends on gmdfs_pkg and gmdfs_stack.
module grid_maze_dfs_path_search #(
   parameter int ROWS        = gmdfs_pkg::ROWS_DEF,
   parameter int COLS        = gmdfs_pkg::COLS_DEF,
   parameter int STACK_DEPTH = gmdfs_pkg::STACK_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // cmd, cell_row, cell_col, wall_bit, start_row, start_col, end_row, end_col
   input  logic [gmdfs_pkg::REQ_W-1:0]     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // found, path_length, cell_mark
   output logic [gmdfs_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_index,
   input  logic [gmdfs_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int N     = ROWS * COLS;
   localparam int AW    = $clog2(N);
   localparam int RI    = $clog2(ROWS);
   localparam int CI    = $clog2(COLS);
   localparam int RSPAN = ROWS > 16 ? ROWS : 16;
   localparam int CSPAN = COLS > 16 ? COLS : 16;
   localparam int RB    = $clog2(RSPAN) + 1;
   localparam int CB    = $clog2(CSPAN) + 1;
   localparam int EW    = RI + CI + 2;
   localparam int TW    = $clog2(STACK_DEPTH + 1);
   localparam int LW    = TW > gmdfs_pkg::LEN_W ? TW : gmdfs_pkg::LEN_W;

   typedef enum logic [7:0] {
      ST_CLEAR      = 8'b0000_0001,
      ST_IDLE       = 8'b0000_0010,
      ST_RD_WAIT    = 8'b0000_0100,
      ST_CHECK      = 8'b0000_1000,
      ST_CHECK_WAIT = 8'b0001_0000,
      ST_POP        = 8'b0010_0000,
      ST_POP_WAIT   = 8'b0100_0000,
      ST_FINISH     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0]                   clr_ff, clr_in;
   logic [RB-1:0]                   cr_ff, cr_in;
   logic [CB-1:0]                   cc_ff, cc_in;
   logic [gmdfs_pkg::COORD_W-1:0]   er_ff, er_in, ec_ff, ec_in;
   logic                            res_found_ff, res_found_in;
   logic [gmdfs_pkg::LEN_W-1:0]     res_len_ff, res_len_in;
   logic [gmdfs_pkg::MARK_W-1:0]    res_mark_ff, res_mark_in;
   logic                            rd_inuse_ff, rd_inuse_in;
   logic [gmdfs_pkg::CFG_W-1:0]     rows_ff, cols_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [gmdfs_pkg::RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [1:0]                      grid_mem [N];
   logic                            grid_we, grid_re;
   logic [AW-1:0]                   grid_waddr, grid_raddr;
   logic [1:0]                      grid_wdata;
   logic [1:0]                      grid_rdata_ff;

   gmdfs_pkg::stk_ctl_type          stk_ctl;
   logic [EW-1:0]                   stk_push_entry;
   logic [EW-1:0]                   stk_pop_entry;
   logic [TW-1:0]                   stk_top;

   logic [gmdfs_pkg::CMD_W-1:0]     f_cmd;
   logic [RB-1:0]                   f_cell_row, f_start_row;
   logic [CB-1:0]                   f_cell_col, f_start_col;
   logic                            f_wall;
   logic [1:0]                      e_dir, e_dir_next;
   logic [RB-1:0]                   e_row, nb_row;
   logic [CB-1:0]                   e_col, nb_col;
   logic [LW-1:0]                   len_raw;
   logic                            req_fire, finish_load;

   function automatic logic in_use_f(input logic [RB-1:0] r, input logic [CB-1:0] c,
                                     input logic [gmdfs_pkg::CFG_W-1:0] nr,
                                     input logic [gmdfs_pkg::CFG_W-1:0] nc);
      return (r < RB'(ROWS)) && (r < RB'(nr)) && (c < CB'(COLS)) && (c < CB'(nc));
   endfunction

   function automatic logic [AW-1:0] addr_f(input logic [RB-1:0] r, input logic [CB-1:0] c);
      return AW'(r[RI-1:0]) * AW'(COLS) + AW'(c[CI-1:0]);
   endfunction

   assign f_cmd       = req_tdata[1:0];
   assign f_cell_row  = RB'(req_tdata[5:2]);
   assign f_cell_col  = CB'(req_tdata[9:6]);
   assign f_wall      = req_tdata[10];
   assign f_start_row = RB'(req_tdata[14:11]);
   assign f_start_col = CB'(req_tdata[18:15]);

   assign e_dir      = stk_pop_entry[1:0];
   assign e_col      = CB'(stk_pop_entry[CI+1:2]);
   assign e_row      = RB'(stk_pop_entry[EW-1:CI+2]);
   assign e_dir_next = e_dir + 2'd1;
   assign len_raw    = LW'(stk_top) + LW'(1);

   always_comb begin
      nb_row = e_row;
      nb_col = e_col;
      case (e_dir_next)
         gmdfs_pkg::DIR_COL_INC: nb_col = e_col + CB'(1);
         gmdfs_pkg::DIR_ROW_INC: nb_row = e_row + RB'(1);
         gmdfs_pkg::DIR_COL_DEC: nb_col = e_col - CB'(1);
         default:                nb_row = e_row - RB'(1);
      endcase
   end

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign finish_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      cr_in          = cr_ff;
      cc_in          = cc_ff;
      er_in          = er_ff;
      ec_in          = ec_ff;
      res_found_in   = res_found_ff;
      res_len_in     = res_len_ff;
      res_mark_in    = res_mark_ff;
      rd_inuse_in    = rd_inuse_ff;
      grid_we        = 1'b0;
      grid_waddr     = addr_f(cr_ff, cc_ff);
      grid_wdata     = gmdfs_pkg::MARK_OPEN;
      grid_re        = 1'b0;
      grid_raddr     = addr_f(cr_ff, cc_ff);
      stk_ctl        = '0;
      stk_push_entry = {cr_ff[RI-1:0], cc_ff[CI-1:0], gmdfs_pkg::DIR_COL_INC};

      unique case (state_ff)
         ST_CLEAR: begin
            grid_we    = 1'b1;
            grid_waddr = clr_ff;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == AW'(N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               res_found_in = 1'b0;
               res_len_in   = '0;
               res_mark_in  = gmdfs_pkg::MARK_OPEN;
               case (f_cmd)
                  gmdfs_pkg::CMD_WRITE: begin
                     grid_we    = (f_cell_row < RB'(ROWS)) && (f_cell_col < CB'(COLS));
                     grid_waddr = addr_f(f_cell_row, f_cell_col);
                     grid_wdata = f_wall ? gmdfs_pkg::MARK_WALL : gmdfs_pkg::MARK_OPEN;
                     state_in   = ST_FINISH;
                  end
                  gmdfs_pkg::CMD_SOLVE: begin
                     cr_in         = f_start_row;
                     cc_in         = f_start_col;
                     er_in         = req_tdata[22:19];
                     ec_in         = req_tdata[26:23];
                     stk_ctl.clear = 1'b1;
                     state_in      = ST_CHECK;
                  end
                  gmdfs_pkg::CMD_READ: begin
                     grid_re     = 1'b1;
                     grid_raddr  = addr_f(f_cell_row, f_cell_col);
                     rd_inuse_in = in_use_f(f_cell_row, f_cell_col, rows_ff, cols_ff);
                     state_in    = ST_RD_WAIT;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            res_mark_in = rd_inuse_ff ? grid_rdata_ff : gmdfs_pkg::MARK_WALL;
            state_in    = ST_FINISH;
         end
         ST_CHECK: begin
            if (in_use_f(cr_ff, cc_ff, rows_ff, cols_ff)) begin
               grid_re  = 1'b1;
               state_in = ST_CHECK_WAIT;
            end else if (stk_top != '0) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CHECK_WAIT: begin
            if (grid_rdata_ff == gmdfs_pkg::MARK_OPEN) begin
               grid_we    = 1'b1;
               grid_wdata = gmdfs_pkg::MARK_PATH;
               if (stk_top >= TW'(STACK_DEPTH)) begin
                  state_in = ST_FINISH;
               end else begin
                  stk_ctl.push = 1'b1;
                  if ((cr_ff == RB'(er_ff)) && (cc_ff == CB'(ec_ff))) begin
                     res_found_in = 1'b1;
                     res_len_in   = (len_raw > LW'(gmdfs_pkg::LEN_MAX)) ?
                                    gmdfs_pkg::LEN_MAX : len_raw[gmdfs_pkg::LEN_W-1:0];
                     state_in     = ST_FINISH;
                  end else begin
                     cc_in    = cc_ff + CB'(1);
                     state_in = ST_CHECK;
                  end
               end
            end else if (stk_top != '0) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_POP: begin
            stk_ctl.pop = 1'b1;
            state_in    = ST_POP_WAIT;
         end
         ST_POP_WAIT: begin
            if ((e_dir == gmdfs_pkg::DIR_ROW_DEC) && (stk_top != '0)) begin
               grid_we     = 1'b1;
               grid_waddr  = addr_f(e_row, e_col);
               grid_wdata  = gmdfs_pkg::MARK_DEAD;
               stk_ctl.pop = 1'b1;
            end else if (e_dir != gmdfs_pkg::DIR_ROW_DEC) begin
               stk_ctl.push   = 1'b1;
               stk_push_entry = {stk_pop_entry[EW-1:2], e_dir_next};
               cr_in          = nb_row;
               cc_in          = nb_col;
               state_in       = ST_CHECK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (finish_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'd0, res_mark_ff, res_len_ff, res_found_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= gmdfs_pkg::SIZE_RESET;
         cols_ff      <= gmdfs_pkg::SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               gmdfs_pkg::CSR_ROWS: rows_ff <= csr_wdata;
               gmdfs_pkg::CSR_COLS: cols_ff <= csr_wdata;
               default:             rows_ff <= rows_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cr_ff        <= cr_in;
      cc_ff        <= cc_in;
      er_ff        <= er_in;
      ec_ff        <= ec_in;
      res_found_ff <= res_found_in;
      res_len_ff   <= res_len_in;
      res_mark_ff  <= res_mark_in;
      rd_inuse_ff  <= rd_inuse_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr] <= grid_wdata;
      end
      if (grid_re) begin
         grid_rdata_ff <= grid_mem[grid_raddr];
      end
   end

   gmdfs_stack #(
      .DEPTH (STACK_DEPTH),
      .EW    (EW)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctl        (stk_ctl),
      .push_entry (stk_push_entry),
      .pop_entry  (stk_pop_entry),
      .top        (stk_top)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stk_top <= TW'(STACK_DEPTH))
      else $error("stack top beyond depth");

   a_found_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[9:1] != '0)
      else $error("found result with empty path");

   a_solve_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && (f_cmd == gmdfs_pkg::CMD_SOLVE) |=> state_ff == ST_CHECK && stk_top == '0)
      else $error("solve did not start with an empty stack");

   a_grid_no_overlap: assert property (@(posedge clock) disable iff (reset)
      grid_we && grid_re |-> state_ff == ST_IDLE && grid_waddr != grid_raddr)
      else $error("grid read and write collide");
`endif

endmodule

/* rtl/core/gmdfs_stack.sv */
// Search stack: one synchronous memory of cell-plus-direction entries and its top counter.
// Depends on gmdfs_pkg for the control struct.
module gmdfs_stack #(
   parameter int DEPTH = gmdfs_pkg::STACK_DEPTH_DEF,
   parameter int EW    = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gmdfs_pkg::stk_ctl_type     ctl,
   input  logic [EW-1:0]              push_entry,
   output logic [EW-1:0]              pop_entry,
   output logic [$clog2(DEPTH+1)-1:0] top
);

   localparam int TW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(DEPTH);

   logic [EW-1:0] stk_mem [DEPTH];
   logic [TW-1:0] top_ff;
   logic [TW-1:0] top_in;
   logic [TW-1:0] top_dec;
   logic [EW-1:0] rd_ff;

   assign top_dec = top_ff - TW'(1);

   always_comb begin
      top_in = top_ff;
      if (ctl.clear) begin
         top_in = '0;
      end else if (ctl.push) begin
         top_in = top_ff + TW'(1);
      end else if (ctl.pop) begin
         top_in = top_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else begin
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         stk_mem[top_ff[SW-1:0]] <= push_entry;
      end
      if (ctl.pop) begin
         rd_ff <= stk_mem[top_dec[SW-1:0]];
      end
   end

   assign pop_entry = rd_ff;
   assign top       = top_ff;

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for grid_maze_dfs_path_search: directed and random maze loads, solves and
// reads checked word by word against a behavioural copy of the search kept inside the bench.
// Depends on gmdfs_pkg and the RTL of the block only.
module tb;

   localparam logic [gmdfs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int GRID_N     = gmdfs_pkg::ROWS_DEF * gmdfs_pkg::COLS_DEF;
   localparam int IDLE_LIMIT = 20000;
   localparam int ITEM_GOAL  = 580;

   typedef logic [3:0]                    coord_type;
   typedef logic [gmdfs_pkg::CFG_W-1:0]   size_type;

   typedef struct packed {
      logic [4:0]                    pad;
      logic [3:0]                    end_col;
      logic [3:0]                    end_row;
      logic [3:0]                    start_col;
      logic [3:0]                    start_row;
      logic                          wall_bit;
      logic [3:0]                    cell_col;
      logic [3:0]                    cell_row;
      logic [gmdfs_pkg::CMD_W-1:0]   cmd;
   } req_word_type;

   typedef struct {
      logic                          found;
      logic [gmdfs_pkg::LEN_W-1:0]   path_length;
      logic [gmdfs_pkg::MARK_W-1:0]  cell_mark;
   } outcome_type;

   logic                        clock;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [gmdfs_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b1;
   logic [gmdfs_pkg::RSP_W-1:0] rsp_tdata;
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   logic [0:0]                  csr_index  = gmdfs_pkg::CSR_ROWS;
   logic [gmdfs_pkg::CFG_W-1:0] csr_wdata  = '0;

   logic [gmdfs_pkg::MARK_W-1:0] grid_mark [GRID_N] = '{default: gmdfs_pkg::MARK_OPEN};
   logic [9:0]                   dfs_stack [gmdfs_pkg::STACK_DEPTH_DEF];
   logic [gmdfs_pkg::CFG_W-1:0]  rows_cfg = gmdfs_pkg::SIZE_RESET;
   logic [gmdfs_pkg::CFG_W-1:0]  cols_cfg = gmdfs_pkg::SIZE_RESET;

   outcome_type outcome_q [$];
   int          errors      = 0;
   int          items_sent  = 0;
   int          idle_cycles = 0;
   int          stall_left  = 0;
   bit          idle_on     = 1'b0;

   grid_maze_dfs_path_search uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int rows_eff();
      return (rows_cfg > gmdfs_pkg::ROWS_DEF) ? gmdfs_pkg::ROWS_DEF : int'(rows_cfg);
   endfunction

   function automatic int cols_eff();
      return (cols_cfg > gmdfs_pkg::COLS_DEF) ? gmdfs_pkg::COLS_DEF : int'(cols_cfg);
   endfunction

   function automatic bit in_area(int r, int c);
      return r >= 0 && c >= 0 && r < rows_eff() && c < cols_eff();
   endfunction

   function automatic bit cell_open(int r, int c);
      return in_area(r, c) && grid_mark[r * gmdfs_pkg::COLS_DEF + c] == gmdfs_pkg::MARK_OPEN;
   endfunction

   function automatic bit maze_search(input int sr, input int sc, input int er, input int ec,
                                      output int depth);
      int         cr;
      int         cc;
      int         pos;
      logic [9:0] ent;
      bit         hit;
      bit         searching;
      cr        = sr;
      cc        = sc;
      depth     = 0;
      hit       = 1'b0;
      searching = 1'b1;
      while (searching) begin
         if (cell_open(cr, cc)) begin
            pos = cr * gmdfs_pkg::COLS_DEF + cc;
            grid_mark[pos] = gmdfs_pkg::MARK_PATH;
            if (depth >= gmdfs_pkg::STACK_DEPTH_DEF) begin
               searching = 1'b0;
            end else begin
               dfs_stack[depth] = {pos[7:0], gmdfs_pkg::DIR_COL_INC};
               depth++;
               if (cr == er && cc == ec) begin
                  hit       = 1'b1;
                  searching = 1'b0;
               end else begin
                  cc++;
               end
            end
         end else if (depth > 0) begin
            depth--;
            ent = dfs_stack[depth];
            while (ent[1:0] == gmdfs_pkg::DIR_ROW_DEC && depth > 0) begin
               grid_mark[ent[9:2]] = gmdfs_pkg::MARK_DEAD;
               depth--;
               ent = dfs_stack[depth];
            end
            if (ent[1:0] != gmdfs_pkg::DIR_ROW_DEC) begin
               ent              = ent + 10'd1;
               dfs_stack[depth] = ent;
               depth++;
               cr = int'(ent[9:6]);
               cc = int'(ent[5:2]);
               case (ent[1:0])
                  gmdfs_pkg::DIR_COL_INC: cc++;
                  gmdfs_pkg::DIR_ROW_INC: cr++;
                  gmdfs_pkg::DIR_COL_DEC: cc--;
                  default:                cr--;
               endcase
            end
         end
         if (searching && depth == 0)
            searching = 1'b0;
      end
      return hit;
   endfunction

   function automatic outcome_type maze_step(req_word_type w);
      outcome_type res;
      int          depth;
      res = '{found: 1'b0, path_length: '0, cell_mark: gmdfs_pkg::MARK_OPEN};
      case (w.cmd)
         gmdfs_pkg::CMD_WRITE: begin
            grid_mark[{w.cell_row, w.cell_col}] = w.wall_bit ? gmdfs_pkg::MARK_WALL :
                                                               gmdfs_pkg::MARK_OPEN;
         end
         gmdfs_pkg::CMD_SOLVE: begin
            if (maze_search(int'(w.start_row), int'(w.start_col), int'(w.end_row),
                            int'(w.end_col), depth)) begin
               res.found       = 1'b1;
               res.path_length = (depth > 511) ? gmdfs_pkg::LEN_MAX :
                                                 depth[gmdfs_pkg::LEN_W-1:0];
            end
         end
         gmdfs_pkg::CMD_READ: begin
            res.cell_mark = in_area(int'(w.cell_row), int'(w.cell_col)) ?
                            grid_mark[{w.cell_row, w.cell_col}] : gmdfs_pkg::MARK_WALL;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 15);
      if (r < 9)
         return 0;
      if (r < 15)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_coord(int n);
      if (n == 0 || $urandom_range(0, 7) == 0)
         return $urandom_range(0, 15);
      return $urandom_range(0, n - 1);
   endfunction

   function automatic size_type pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            default: return 5'd31;
         endcase
      end
      if (r == 1)
         return size_type'($urandom_range(9, 16));
      return size_type'($urandom_range(2, 7));
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      outcome_q.push_back(maze_step(w));
      items_sent++;
   endtask

   task automatic write_cell(input int r, input int c, input bit wall);
      req_word_type w;
      w          = '0;
      w.cmd      = gmdfs_pkg::CMD_WRITE;
      w.cell_row = coord_type'(r);
      w.cell_col = coord_type'(c);
      w.wall_bit = wall;
      send_word(w);
   endtask

   task automatic read_cell(input int r, input int c);
      req_word_type w;
      w          = '0;
      w.cmd      = gmdfs_pkg::CMD_READ;
      w.cell_row = coord_type'(r);
      w.cell_col = coord_type'(c);
      send_word(w);
   endtask

   task automatic solve_maze(input int sr, input int sc, input int er, input int ec);
      req_word_type w;
      w           = '0;
      w.cmd       = gmdfs_pkg::CMD_SOLVE;
      w.start_row = coord_type'(sr);
      w.start_col = coord_type'(sc);
      w.end_row   = coord_type'(er);
      w.end_col   = coord_type'(ec);
      send_word(w);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_size(input size_type r, input size_type c);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= gmdfs_pkg::CSR_ROWS;
      csr_wdata <= r;
      do @(posedge clock); while (!csr_ready);
      rows_cfg  = r;
      csr_index <= gmdfs_pkg::CSR_COLS;
      csr_wdata <= c;
      do @(posedge clock); while (!csr_ready);
      cols_cfg  = c;
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_marks();
      idle_on = 1'b0;
      read_cell(0, 0);
      read_cell(9, 9);
      read_cell(10, 0);
      read_cell(0, 10);
      read_cell(15, 15);
   endtask

   task automatic test_directed_cases();
      req_word_type w;
      set_size(5'd4, 5'd4);
      solve_maze(0, 0, 3, 3);
      read_cell(0, 3);
      read_cell(3, 0);
      solve_maze(0, 0, 3, 3);
      write_cell(0, 0, 1'b0);
      write_cell(0, 1, 1'b1);
      solve_maze(0, 0, 15, 15);
      read_cell(1, 0);
      read_cell(0, 1);
      w     = '1;
      w.pad = '0;
      w.cmd = CMD_UNUSED;
      send_word(w);
      set_size(5'd0, 5'd31);
      solve_maze(0, 0, 0, 0);
      read_cell(0, 0);
      set_size(5'd31, 5'd31);
      write_cell(15, 15, 1'b1);
      read_cell(15, 15);
      write_cell(15, 15, 1'b0);
      solve_maze(15, 15, 15, 15);
      read_cell(15, 15);
      set_size(5'd1, 5'd1);
      write_cell(0, 0, 1'b0);
      solve_maze(0, 0, 0, 0);
   endtask

   task automatic test_random_mazes();
      int           sr;
      int           sc;
      int           er;
      int           ec;
      int           n;
      bit           first;
      req_word_type w;
      first = 1'b1;
      while (items_sent < ITEM_GOAL) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if (first || $urandom_range(0, 1) == 0)
            set_size(pick_size(), pick_size());
         first = 1'b0;
         for (int r = 0; r < rows_eff(); r++)
            for (int c = 0; c < cols_eff(); c++)
               write_cell(r, c, $urandom_range(0, 9) < 3);
         sr = pick_coord(rows_eff());
         sc = pick_coord(cols_eff());
         er = pick_coord(rows_eff());
         ec = pick_coord(cols_eff());
         if ($urandom_range(0, 7) != 0) begin
            write_cell(sr, sc, 1'b0);
            write_cell(er, ec, 1'b0);
         end
         solve_maze(sr, sc, er, ec);
         n = $urandom_range(2, 6);
         repeat (n) read_cell(pick_coord(rows_eff()), pick_coord(cols_eff()));
         if ($urandom_range(0, 2) == 0) begin
            solve_maze(pick_coord(rows_eff()), pick_coord(cols_eff()),
                       pick_coord(rows_eff()), pick_coord(cols_eff()));
            read_cell(pick_coord(rows_eff()), pick_coord(cols_eff()));
         end
         if ($urandom_range(0, 9) == 0) begin
            w     = $urandom;
            w.pad = '0;
            if ($urandom_range(0, 1) == 0)
               w.cmd = CMD_UNUSED;
            send_word(w);
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else
         stall_left = pick_gap();
      rsp_tready <= (stall_left == 0);
   end

   always @(posedge clock) begin : check_rsp
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: result word %h arrived with none expected", $time, rsp_tdata);
            errors++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tdata[0] !== want.found) begin
               $display("%0t: found expected %0d actual %0d", $time, want.found, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[9:1] !== want.path_length) begin
               $display("%0t: path_length expected %0d actual %0d", $time, want.path_length,
                        rsp_tdata[9:1]);
               errors++;
            end
            if (rsp_tdata[11:10] !== want.cell_mark) begin
               $display("%0t: cell_mark expected %0d actual %0d", $time, want.cell_mark,
                        rsp_tdata[11:10]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_marks();
      test_directed_cases();
      test_random_mazes();
      wait_idle();
      repeat (40) @(posedge clock);
      if (errors == 0 && outcome_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* files.f */
rtl/core/gmdfs_pkg.sv
rtl/core/gmdfs_stack.sv
rtl/core/grid_maze_dfs_path_search.sv
tb/sv/tb.sv
